// ===== design/pes_pkg.sv =====
// Package of the periodic event scheduler: opcodes, word layouts and sizes.
// Used by the interfaces and the scheduler core.
`timescale 1ns / 1ps
`default_nettype none
package pes_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned MAX_REPORTS  = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [15:0]         elapsed;
    logic                halt;
    logic [31:0]         start_time;
    logic [31:0]         period;
    logic [15:0]         repeat_limit;
    logic [7:0]          kind_id;
    logic [7:0]          move_pattern;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic [31:0]         pattern_word;
  } in_t;

  typedef struct packed {
    logic                fired;
    logic [3:0]          channel;
    logic [7:0]          out_kind_id;
    logic [7:0]          out_move_pattern;
    logic signed [15:0]  out_pos_x;
    logic signed [15:0]  out_pos_y;
    logic [31:0]         out_pattern_word;
    logic                load_rejected;
    logic                all_done;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] period;
    logic [15:0] limit;
    logic [15:0] count;
    logic [31:0] last_fire;
  } timing_t;

  typedef struct packed {
    logic [7:0]  kind_id;
    logic [7:0]  move_pattern;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] pattern_word;
  } payload_t;

endpackage
`default_nettype wire

// ===== design/pes_if.sv =====
// Valid/ready channels of the periodic event scheduler.
// Depends on pes_pkg for the word layouts.
`timescale 1ns / 1ps
`default_nettype none
interface pes_in_if;
  import pes_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pes_out_if;
  import pes_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pes_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
// Holds one channel field group per entry; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module pes_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned W     = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== design/periodic_event_scheduler_core.sv =====
// Top level of the periodic event scheduler: sequencer over the channel tables.
// Depends on pes_pkg, pes_if and pes_ram.
`timescale 1ns / 1ps
`default_nettype none
// Load, clear, halted ticks and unused opcodes give one word. A tick walks
// the timing table one entry per cycle through a two-stage read-modify-write
// loop, then scans the fired mask and reads the payload table for each
// channel that fired, giving one word per firing, or one plain word if none
// fired. Results wait in an output register.
module periodic_event_scheduler_core #(
  parameter int unsigned CHANNELS = pes_pkg::CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pes_in_if.sink    in_i,
  pes_out_if.source out_o
);
  import pes_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW = $clog2(CHANNELS + 1);
  localparam int unsigned NW = $clog2(MAX_REPORTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PLAIN, S_UPD, S_EMIT_SCAN, S_EMIT_LOAD
  } state_e;

  state_e               state_q, state_d;
  logic [31:0]          clock_q, clock_d;
  logic [CW-1:0]        used_q, used_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 p1_v_q, p1_v_d;
  logic [AW-1:0]        p1_idx_q, p1_idx_d;
  logic [NW-1:0]        n_q, n_d;
  logic [NW-1:0]        e_q, e_d;
  logic                 rej_q, rej_d;
  logic [CHANNELS-1:0]  mask_q, mask_d;
  logic [CHANNELS-1:0]  ended_q, ended_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic          tm_we, tm_re, pl_we, pl_re;
  logic [AW-1:0] tm_waddr, tm_raddr, pl_raddr;
  timing_t       tm_wdata, tm_rdata, t;
  payload_t      pl_wdata, pl_rdata;
  logic          all_done;
  logic          out_free;
  logic [32:0]   sum;
  logic [15:0]   cnt_next;
  logic          is_last;

  pes_ram #(.DEPTH(CHANNELS), .AW(AW), .W($bits(timing_t))) u_timing (
    .clk_i, .we_i(tm_we), .waddr_i(tm_waddr), .wdata_i(tm_wdata),
    .re_i(tm_re), .raddr_i(tm_raddr), .rdata_o(tm_rdata)
  );

  pes_ram #(.DEPTH(CHANNELS), .AW(AW), .W($bits(payload_t))) u_payload (
    .clk_i, .we_i(pl_we), .waddr_i(used_q[AW-1:0]), .wdata_i(pl_wdata),
    .re_i(pl_re), .raddr_i(pl_raddr), .rdata_o(pl_rdata)
  );

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((CW'(i) < used_q) && !ended_q[i]) begin
        all_done = 1'b0;
      end
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    clock_d     = clock_q;
    used_d      = used_q;
    idx_d       = idx_q;
    p1_v_d      = 1'b0;
    p1_idx_d    = p1_idx_q;
    n_d         = n_q;
    e_d         = e_q;
    rej_d       = rej_q;
    mask_d      = mask_q;
    ended_d     = ended_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    tm_we       = 1'b0;
    tm_re       = 1'b0;
    pl_we       = 1'b0;
    pl_re       = 1'b0;
    tm_waddr    = used_q[AW-1:0];
    tm_raddr    = idx_q[AW-1:0];
    pl_raddr    = idx_q[AW-1:0];
    tm_wdata    = '{start: in_i.data.start_time, period: in_i.data.period,
                    limit: in_i.data.repeat_limit, count: 16'd0, last_fire: 32'd0};
    pl_wdata    = '{kind_id: in_i.data.kind_id, move_pattern: in_i.data.move_pattern,
                    pos_x: in_i.data.pos_x, pos_y: in_i.data.pos_y,
                    pattern_word: in_i.data.pattern_word};
    t           = tm_rdata;
    sum         = {1'b0, clock_q} + 33'(in_i.data.elapsed);
    cnt_next    = t.count + 16'd1;
    is_last     = (e_q == n_q - NW'(1));

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rej_d   = 1'b0;
          state_d = S_PLAIN;
          case (opcode_e'(in_i.data.opcode))
            OP_LOAD: begin
              if (used_q < CW'(CHANNELS)) begin
                tm_we = 1'b1;
                pl_we = 1'b1;
                ended_d[used_q[AW-1:0]] = 1'b0;
                used_d = used_q + CW'(1);
              end else begin
                rej_d = 1'b1;
              end
            end
            OP_CLEAR: begin
              used_d  = '0;
              clock_d = '0;
            end
            OP_TICK: begin
              if (!in_i.data.halt) begin
                clock_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                idx_d   = '0;
                n_d     = '0;
                mask_d  = '0;
                state_d = S_UPD;
              end
            end
            default: begin
              state_d = S_PLAIN;
            end
          endcase
        end
      end
      S_PLAIN: begin
        if (out_free) begin
          out_d               = '0;
          out_d.load_rejected = rej_q;
          out_d.all_done      = all_done;
          out_d.last          = 1'b1;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_UPD: begin
        if (idx_q < used_q) begin
          tm_re    = 1'b1;
          p1_v_d   = 1'b1;
          p1_idx_d = idx_q[AW-1:0];
          idx_d    = idx_q + CW'(1);
        end else if (!p1_v_q) begin
          idx_d   = '0;
          e_d     = '0;
          state_d = (n_q == '0) ? S_PLAIN : S_EMIT_SCAN;
        end
        if (p1_v_q && !ended_q[p1_idx_q] && (t.start <= clock_q) &&
            ((t.count == 16'd0) || ((clock_q - t.last_fire) >= t.period)) &&
            (n_q < NW'(MAX_REPORTS))) begin
          tm_we            = 1'b1;
          tm_waddr         = p1_idx_q;
          tm_wdata         = t;
          tm_wdata.count   = cnt_next;
          tm_wdata.last_fire = clock_q;
          if (cnt_next >= t.limit) begin
            ended_d[p1_idx_q] = 1'b1;
          end
          mask_d[p1_idx_q] = 1'b1;
          n_d = n_q + NW'(1);
        end
      end
      S_EMIT_SCAN: begin
        if (mask_q[idx_q[AW-1:0]]) begin
          pl_re   = 1'b1;
          state_d = S_EMIT_LOAD;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_EMIT_LOAD: begin
        if (out_free) begin
          out_d.fired            = 1'b1;
          out_d.channel          = 4'(idx_q);
          out_d.out_kind_id      = pl_rdata.kind_id;
          out_d.out_move_pattern = pl_rdata.move_pattern;
          out_d.out_pos_x        = pl_rdata.pos_x;
          out_d.out_pos_y        = pl_rdata.pos_y;
          out_d.out_pattern_word = pl_rdata.pattern_word;
          out_d.load_rejected    = 1'b0;
          out_d.all_done         = all_done;
          out_d.last             = is_last;
          out_valid_d            = 1'b1;
          e_d                    = e_q + NW'(1);
          idx_d                  = idx_q + CW'(1);
          state_d                = is_last ? S_IDLE : S_EMIT_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clock_q     <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      p1_v_q      <= 1'b0;
      p1_idx_q    <= '0;
      n_q         <= '0;
      e_q         <= '0;
      rej_q       <= 1'b0;
      mask_q      <= '0;
      ended_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      p1_v_q      <= p1_v_d;
      p1_idx_q    <= p1_idx_d;
      n_q         <= n_d;
      e_q         <= e_d;
      rej_q       <= rej_d;
      mask_q      <= mask_d;
      ended_q     <= ended_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_reports_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_REPORTS))
    else $error("firing count exceeds the report limit");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(CHANNELS))
    else $error("channel count exceeds the table depth");

  a_emit_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_LOAD) |-> (mask_q[idx_q[AW-1:0]] && (n_q != '0)))
    else $error("emitting a channel that did not fire");

  a_fired_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fired) |-> !out_q.load_rejected)
    else $error("fired word flagged as a rejected load");
endmodule
`default_nettype wire
